>>> hw/rtl/radio_frame_joystick_drive_macros.svh
// Assertion macros used by the top level of the radio frame joystick drive RTL.
`ifndef RADIO_FRAME_JOYSTICK_DRIVE_MACROS_SVH
`define RADIO_FRAME_JOYSTICK_DRIVE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RFJD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RFJD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rfjd_pkg.sv
// Types and constants of the radio frame joystick drive.
package rfjd_pkg;

  localparam int unsigned AXIS_W = 10;

  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] LEN_HI_BYTE = 8'h00;
  localparam logic [7:0] LEN_LO_BYTE = 8'h10;
  localparam logic [7:0] FRAME_TYPE  = 8'h83;
  localparam logic [7:0] CSUM_BASE   = 8'hFF;

  localparam logic [3:0] PAY_LAST     = 4'd14;
  localparam logic [3:0] IDX_DIGITAL  = 4'd8;
  localparam logic [3:0] IDX_AXIS1_HI = 4'd11;
  localparam logic [3:0] IDX_AXIS1_LO = 4'd12;
  localparam logic [3:0] IDX_AXIS2_HI = 4'd13;
  localparam logic [3:0] IDX_AXIS2_LO = 4'd14;
  localparam int unsigned DIGITAL_BIT = 3;

  localparam logic [AXIS_W-1:0] AXIS_MAX      = 10'd1023;
  localparam logic [AXIS_W-1:0] FWD_LIMIT_RST = 10'd400;
  localparam logic [AXIS_W-1:0] REV_LIMIT_RST = 10'd750;

  // Register index, taken from paddr bit 2.
  localparam logic REG_FORWARD_LIMIT = 1'b0;
  localparam logic REG_REVERSE_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CSUM
  } phase_t;

  typedef struct packed {
    logic              fire;
    logic              ok;
    logic              digital;
    logic [AXIS_W-1:0] axis_one;
    logic [AXIS_W-1:0] axis_two;
  } commit_t;

  // Big-endian word, clipped to the axis range.
  function automatic logic [AXIS_W-1:0] word_sat(input logic [7:0] hi, input logic [7:0] lo);
    logic [AXIS_W-1:0] w;
    w = {hi[1:0], lo};
    if (hi[7:2] != 6'd0) begin
      w = AXIS_MAX;
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/rfjd_parser.sv
// Frame parser: header match, checksum, payload staging and committed values.
module rfjd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             csum_phase,
  output rfjd_pkg::commit_t commit
);
  import rfjd_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              stage_dig_r;
  logic [7:0]        a1_hi_r, a1_lo_r, a2_hi_r, a2_lo_r;
  logic              kept_dig_r, kept_dig_nxt;
  logic [AXIS_W-1:0] kept_a1_r, kept_a1_nxt;
  logic [AXIS_W-1:0] kept_a2_r, kept_a2_nxt;
  logic              fire, ok;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    kept_dig_nxt = kept_dig_r;
    kept_a1_nxt = kept_a1_r;
    kept_a2_nxt = kept_a2_r;
    fire        = 1'b0;
    ok          = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == START_BYTE) phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          phase_nxt = (rx_byte == LEN_HI_BYTE) ? PH_LEN_LO : PH_HUNT;
        end
        PH_LEN_LO: begin
          phase_nxt = (rx_byte == LEN_LO_BYTE) ? PH_TYPE : PH_HUNT;
        end
        PH_TYPE: begin
          if (rx_byte == FRAME_TYPE) begin
            sum_nxt   = FRAME_TYPE;
            idx_nxt   = 4'd0;
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt = sum_r + rx_byte;
          idx_nxt = idx_r + 4'd1;
          if (idx_r == PAY_LAST) phase_nxt = PH_CSUM;
        end
        PH_CSUM: begin
          phase_nxt = PH_HUNT;
          fire      = 1'b1;
          ok        = (rx_byte == (CSUM_BASE - sum_r));
          if (ok) begin
            kept_dig_nxt = stage_dig_r;
            kept_a1_nxt  = word_sat(a1_hi_r, a1_lo_r);
            kept_a2_nxt  = word_sat(a2_hi_r, a2_lo_r);
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      idx_r      <= 4'd0;
      sum_r      <= 8'd0;
      kept_dig_r <= 1'b0;
      kept_a1_r  <= '0;
      kept_a2_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      kept_dig_r <= kept_dig_nxt;
      kept_a1_r  <= kept_a1_nxt;
      kept_a2_r  <= kept_a2_nxt;
    end
  end

  // Stage the payload bytes that a good frame commits.
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_PAYLOAD) begin
      case (idx_r)
        IDX_DIGITAL:  stage_dig_r <= rx_byte[DIGITAL_BIT];
        IDX_AXIS1_HI: a1_hi_r <= rx_byte;
        IDX_AXIS1_LO: a1_lo_r <= rx_byte;
        IDX_AXIS2_HI: a2_hi_r <= rx_byte;
        IDX_AXIS2_LO: a2_lo_r <= rx_byte;
        default: begin
        end
      endcase
    end
  end

  assign csum_phase      = (phase_r == PH_CSUM);
  assign commit.fire     = fire;
  assign commit.ok       = ok;
  assign commit.digital  = kept_dig_nxt;
  assign commit.axis_one = kept_a1_nxt;
  assign commit.axis_two = kept_a2_nxt;

endmodule

>>> hw/rtl/rfjd_drive.sv
// Drive decode and result register: bridge pin levels from committed axes.
module rfjd_drive (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rfjd_pkg::commit_t         commit,
  input  logic [rfjd_pkg::AXIS_W-1:0] forward_limit,
  input  logic [rfjd_pkg::AXIS_W-1:0] reverse_limit,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_frame_valid,
  output logic                      out_left_in1,
  output logic                      out_left_in2,
  output logic                      out_right_in1,
  output logic                      out_right_in2,
  output logic                      out_magnet_on,
  output logic [rfjd_pkg::AXIS_W-1:0] out_axis_one,
  output logic [rfjd_pkg::AXIS_W-1:0] out_axis_two
);
  import rfjd_pkg::*;

  logic              valid_r, valid_nxt;
  logic              ok_r, l1_r, l2_r, r1_r, r2_r, mag_r;
  logic [AXIS_W-1:0] a1_r, a2_r;
  logic              one_below, one_above, two_below, two_above;
  logic              l1, l2, r1, r2;

  // Below the band wins; above only counts outside it.
  assign one_below = commit.axis_one < forward_limit;
  assign one_above = !one_below && (commit.axis_one > reverse_limit);
  assign two_below = commit.axis_two < forward_limit;
  assign two_above = !two_below && (commit.axis_two > reverse_limit);

  always_comb begin
    l1 = 1'b0;
    l2 = 1'b0;
    r1 = 1'b0;
    r2 = 1'b0;
    if (one_below) begin
      l2 = 1'b1;
      r2 = 1'b1;
    end else if (one_above) begin
      l1 = 1'b1;
      r1 = 1'b1;
    end else if (two_above) begin
      l2 = 1'b1;
      r1 = 1'b1;
    end else if (two_below) begin
      l1 = 1'b1;
      r2 = 1'b1;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (commit.fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit.fire) begin
      ok_r  <= commit.ok;
      l1_r  <= l1;
      l2_r  <= l2;
      r1_r  <= r1;
      r2_r  <= r2;
      mag_r <= !commit.digital;
      a1_r  <= commit.axis_one;
      a2_r  <= commit.axis_two;
    end
  end

  assign out_valid       = valid_r;
  assign out_frame_valid = ok_r;
  assign out_left_in1    = l1_r;
  assign out_left_in2    = l2_r;
  assign out_right_in1   = r1_r;
  assign out_right_in2   = r2_r;
  assign out_magnet_on   = mag_r;
  assign out_axis_one    = a1_r;
  assign out_axis_two    = a2_r;

endmodule

>>> hw/rtl/radio_frame_joystick_drive.sv
// Top level of the radio frame joystick drive: register port, parser, drive decode.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   in       | in_valid/in_ready  | in_rx_byte
//   out      | out_valid/out_ready| out_frame_valid, bridge pins, magnet, axes
//   cfg      | APB psel/penable   | forward_limit @0x0, reverse_limit @0x4
//
// One byte per cycle; a checksum byte yields its result in the next cycle from
// the result register. in_ready drops only while a result waits untaken and
// the parser sits on the checksum byte. Reset clears the parser, the committed
// values and the limits to 400 and 750; staged payload bytes are not reset.
module radio_frame_joystick_drive (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_frame_valid,
  output logic                      out_left_in1,
  output logic                      out_left_in2,
  output logic                      out_right_in1,
  output logic                      out_right_in2,
  output logic                      out_magnet_on,
  output logic [rfjd_pkg::AXIS_W-1:0] out_axis_one,
  output logic [rfjd_pkg::AXIS_W-1:0] out_axis_two,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rfjd_pkg::*;
  `include "radio_frame_joystick_drive_macros.svh"

  logic [AXIS_W-1:0] fwd_limit_r, fwd_limit_nxt;
  logic [AXIS_W-1:0] rev_limit_r, rev_limit_nxt;
  logic              cfg_write;
  logic              csum_phase;
  logic              accept;
  commit_t           commit;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    fwd_limit_nxt = fwd_limit_r;
    rev_limit_nxt = rev_limit_r;
    if (cfg_write) begin
      case (paddr[2])
        REG_FORWARD_LIMIT: fwd_limit_nxt = pwdata[AXIS_W-1:0];
        REG_REVERSE_LIMIT: rev_limit_nxt = pwdata[AXIS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_limit_r <= FWD_LIMIT_RST;
      rev_limit_r <= REV_LIMIT_RST;
    end else begin
      fwd_limit_r <= fwd_limit_nxt;
      rev_limit_r <= rev_limit_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FORWARD_LIMIT: prdata = {{(32-AXIS_W){1'b0}}, fwd_limit_r};
      REG_REVERSE_LIMIT: prdata = {{(32-AXIS_W){1'b0}}, rev_limit_r};
      default:           prdata = 32'd0;
    endcase
  end

  // Hold only the checksum byte while a result is still waiting.
  assign in_ready = !csum_phase || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rfjd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .csum_phase (csum_phase),
    .commit     (commit)
  );

  rfjd_drive u_drive (
    .clk             (clk),
    .rst_n           (rst_n),
    .commit          (commit),
    .forward_limit   (fwd_limit_r),
    .reverse_limit   (rev_limit_r),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_frame_valid (out_frame_valid),
    .out_left_in1    (out_left_in1),
    .out_left_in2    (out_left_in2),
    .out_right_in1   (out_right_in1),
    .out_right_in2   (out_right_in2),
    .out_magnet_on   (out_magnet_on),
    .out_axis_one    (out_axis_one),
    .out_axis_two    (out_axis_two)
  );

  `RFJD_ASSERT_NOW(a_bridge_no_short, out_valid, !(out_left_in1 && out_left_in2) && !(out_right_in1 && out_right_in2), "bridge input pair driven high together")
  `RFJD_ASSERT_NOW(a_sides_together, out_valid, (out_left_in1 || out_left_in2) == (out_right_in1 || out_right_in2), "only one motor side driven")
  `RFJD_ASSERT_NEXT(a_no_spurious_item, !accept && !out_valid, !out_valid, "result item without an accepted byte")

endmodule

>>> sim/rfjd_drive_checker.sv
// Checker for the radio frame joystick drive: predicts drive results from accepted bytes.
`timescale 1ns / 100ps

module rfjd_drive_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_frame_valid,
  input  logic                        out_left_in1,
  input  logic                        out_left_in2,
  input  logic                        out_right_in1,
  input  logic                        out_right_in2,
  input  logic                        out_magnet_on,
  input  logic [rfjd_pkg::AXIS_W-1:0] out_axis_one,
  input  logic [rfjd_pkg::AXIS_W-1:0] out_axis_two,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          mismatch_count,
  output int                          pending_results
);
  import rfjd_pkg::*;

  typedef struct packed {
    logic              frame_valid;
    logic              left_in1;
    logic              left_in2;
    logic              right_in1;
    logic              right_in2;
    logic              magnet_on;
    logic [AXIS_W-1:0] axis_one;
    logic [AXIS_W-1:0] axis_two;
  } drive_result_t;

  typedef enum logic [1:0] {
    SENSE_NEUTRAL,
    SENSE_LOW,
    SENSE_HIGH
  } axis_sense_t;

  drive_result_t     expected_drive[$];
  drive_result_t     want;
  drive_result_t     fresh;

  phase_t            frame_phase;
  logic [3:0]        pay_idx;
  logic [7:0]        frame_sum;
  logic [7:0]        digital_byte;
  logic [7:0]        axis_one_hi;
  logic [7:0]        axis_one_lo;
  logic [7:0]        axis_two_hi;
  logic [7:0]        axis_two_lo;
  logic              kept_bit;
  logic [AXIS_W-1:0] kept_one;
  logic [AXIS_W-1:0] kept_two;
  logic [AXIS_W-1:0] fwd_limit;
  logic [AXIS_W-1:0] rev_limit;
  int                errors = 0;

  assign mismatch_count = errors;

  function automatic logic [AXIS_W-1:0] clip_word(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] w;
    w = {hi, lo};
    return (w > 16'(AXIS_MAX)) ? AXIS_MAX : w[AXIS_W-1:0];
  endfunction

  function automatic axis_sense_t sense_of(input logic [AXIS_W-1:0] v);
    if (v >= fwd_limit && v <= rev_limit) return SENSE_NEUTRAL;
    if (v < fwd_limit) return SENSE_LOW;
    return SENSE_HIGH;
  endfunction

  // Advance the frame parser by one byte; returns 1 when a drive result falls out.
  function automatic bit parse_radio_byte(input logic [7:0] b, output drive_result_t r);
    axis_sense_t s_one;
    axis_sense_t s_two;
    logic        good;
    r = '0;
    case (frame_phase)
      PH_HUNT: begin
        if (b == START_BYTE) frame_phase = PH_LEN_HI;
      end
      PH_LEN_HI: frame_phase = (b == LEN_HI_BYTE) ? PH_LEN_LO : PH_HUNT;
      PH_LEN_LO: frame_phase = (b == LEN_LO_BYTE) ? PH_TYPE : PH_HUNT;
      PH_TYPE: begin
        if (b == FRAME_TYPE) begin
          frame_sum = FRAME_TYPE;
          pay_idx = '0;
          frame_phase = PH_PAYLOAD;
        end else begin
          frame_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        frame_sum = frame_sum + b;
        case (pay_idx)
          IDX_DIGITAL:  digital_byte = b;
          IDX_AXIS1_HI: axis_one_hi = b;
          IDX_AXIS1_LO: axis_one_lo = b;
          IDX_AXIS2_HI: axis_two_hi = b;
          IDX_AXIS2_LO: axis_two_lo = b;
          default: ;
        endcase
        if (pay_idx == PAY_LAST) frame_phase = PH_CSUM;
        else pay_idx = pay_idx + 4'd1;
      end
      PH_CSUM: begin
        frame_phase = PH_HUNT;
        good = (b == CSUM_BASE - frame_sum);
        if (good) begin
          kept_bit = digital_byte[DIGITAL_BIT];
          kept_one = clip_word(axis_one_hi, axis_one_lo);
          kept_two = clip_word(axis_two_hi, axis_two_lo);
        end
        s_one = sense_of(kept_one);
        s_two = sense_of(kept_two);
        // Forward, backward, right turn, left turn, then stop.
        if (s_one == SENSE_LOW) begin
          r.left_in2 = 1'b1;
          r.right_in2 = 1'b1;
        end else if (s_one == SENSE_HIGH) begin
          r.left_in1 = 1'b1;
          r.right_in1 = 1'b1;
        end else if (s_two == SENSE_HIGH) begin
          r.left_in2 = 1'b1;
          r.right_in1 = 1'b1;
        end else if (s_two == SENSE_LOW) begin
          r.left_in1 = 1'b1;
          r.right_in2 = 1'b1;
        end
        r.frame_valid = good;
        r.magnet_on = ~kept_bit;
        r.axis_one = kept_one;
        r.axis_two = kept_two;
        return 1'b1;
      end
      default: frame_phase = PH_HUNT;
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string label, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_phase = PH_HUNT;
      pay_idx = '0;
      frame_sum = '0;
      kept_bit = 1'b0;
      kept_one = '0;
      kept_two = '0;
      fwd_limit = FWD_LIMIT_RST;
      rev_limit = REV_LIMIT_RST;
      expected_drive.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          errors++;
          $display("%0t: result with no expected item, got valid %0b axes %0d %0d",
                   $time, out_frame_valid, out_axis_one, out_axis_two);
        end else begin
          want = expected_drive.pop_front();
          check_field("frame_valid", want.frame_valid, out_frame_valid);
          check_field("left_in1", want.left_in1, out_left_in1);
          check_field("left_in2", want.left_in2, out_left_in2);
          check_field("right_in1", want.right_in1, out_right_in1);
          check_field("right_in2", want.right_in2, out_right_in2);
          check_field("magnet_on", want.magnet_on, out_magnet_on);
          check_field("axis_one", want.axis_one, out_axis_one);
          check_field("axis_two", want.axis_two, out_axis_two);
        end
      end
      if (in_valid && in_ready) begin
        if (parse_radio_byte(in_rx_byte, fresh)) expected_drive.push_back(fresh);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_REVERSE_LIMIT) rev_limit = pwdata[AXIS_W-1:0];
          else fwd_limit = pwdata[AXIS_W-1:0];
        end else begin
          check_field("prdata", (paddr[2] == REG_REVERSE_LIMIT) ? rev_limit : fwd_limit,
                      prdata[AXIS_W-1:0]);
        end
      end
    end
    pending_results <= expected_drive.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the radio frame joystick drive: stimulus, receiver, watchdog, verdict.
`timescale 1ns / 100ps

module tb_top;
  import rfjd_pkg::*;

  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 270;
  localparam int QUIET_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_frame_valid;
  logic              out_left_in1;
  logic              out_left_in2;
  logic              out_right_in1;
  logic              out_right_in2;
  logic              out_magnet_on;
  logic [AXIS_W-1:0] out_axis_one;
  logic [AXIS_W-1:0] out_axis_two;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = 3'd0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  int                mismatch_count;
  int                pending_results;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                long_holds_asked = 0;
  int                long_holds_served = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  logic [AXIS_W-1:0] fwd_set = FWD_LIMIT_RST;
  logic [AXIS_W-1:0] rev_set = REV_LIMIT_RST;
  logic [7:0]        frame_payload [15];
  logic [7:0]        header_bytes [4] = '{START_BYTE, LEN_HI_BYTE, LEN_LO_BYTE, FRAME_TYPE};
  // Start, repeated start, bad length high, bad length low, bad frame type.
  logic [7:0]        opening_bytes [10] = '{START_BYTE, START_BYTE, LEN_HI_BYTE,
                                            START_BYTE, LEN_HI_BYTE, 8'h11,
                                            START_BYTE, LEN_HI_BYTE, LEN_LO_BYTE, 8'h84};

  radio_frame_joystick_drive dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_valid(out_frame_valid),
    .out_left_in1(out_left_in1), .out_left_in2(out_left_in2),
    .out_right_in1(out_right_in1), .out_right_in2(out_right_in2),
    .out_magnet_on(out_magnet_on),
    .out_axis_one(out_axis_one), .out_axis_two(out_axis_two),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rfjd_drive_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_valid(out_frame_valid),
    .out_left_in1(out_left_in1), .out_left_in2(out_left_in2),
    .out_right_in1(out_right_in1), .out_right_in2(out_right_in2),
    .out_magnet_on(out_magnet_on),
    .out_axis_one(out_axis_one), .out_axis_two(out_axis_two),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  always #2 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (long_holds_served != long_holds_asked) begin
      long_holds_served <= long_holds_asked;
      stall_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input bit spoil_sum);
    logic [7:0] sum;
    sum = FRAME_TYPE;
    foreach (header_bytes[i]) send_byte(header_bytes[i]);
    foreach (frame_payload[i]) begin
      send_byte(frame_payload[i]);
      sum = sum + frame_payload[i];
    end
    sum = CSUM_BASE - sum;
    if (spoil_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Values around the limits, random values in range, and some beyond the axis range.
  function automatic logic [15:0] pick_axis_word();
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom_range(1023));
      3:       return 16'(fwd_set - 10'd1);
      4:       return 16'(fwd_set);
      5:       return 16'(rev_set);
      6:       return 16'(rev_set + 10'd1);
      7:       return {8'($urandom_range(4, 255)), 8'($urandom_range(255))};
      8:       return ($urandom_range(1) != 0) ? 16'd1023 : 16'd1024;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic fill_payload();
    logic [15:0] w;
    foreach (frame_payload[i]) frame_payload[i] = 8'($urandom_range(255));
    w = pick_axis_word();
    frame_payload[IDX_AXIS1_HI] = w[15:8];
    frame_payload[IDX_AXIS1_LO] = w[7:0];
    w = pick_axis_word();
    frame_payload[IDX_AXIS2_HI] = w[15:8];
    frame_payload[IDX_AXIS2_LO] = w[7:0];
  endtask

  task automatic cfg_access(input bit is_write, input logic reg_sel,
                            input logic [AXIS_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {reg_sel, 2'b00};
    // Upper bits are random: the block keeps only the low ten.
    pwdata <= ($urandom() & 32'hFFFF_FC00) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input logic [AXIS_W-1:0] fwd, input logic [AXIS_W-1:0] rev);
    cfg_access(1'b1, REG_FORWARD_LIMIT, fwd);
    cfg_access(1'b1, REG_REVERSE_LIMIT, rev);
    fwd_set = fwd;
    rev_set = rev;
    cfg_access(1'b0, REG_FORWARD_LIMIT, '0);
    cfg_access(1'b0, REG_REVERSE_LIMIT, '0);
  endtask

  initial begin
    int fed;
    int k;
    int pick;
    bit hold_done;
    logic [7:0] bad;
    logic [AXIS_W-1:0] lo_lim;
    logic [AXIS_W-1:0] hi_lim;

    hold_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 59 : 0;
      recv_idle_pct = (seg < 2) ? 59 : (seg < 4) ? 33 : 0;
      if (seg == 0) begin
        cfg_access(1'b0, REG_FORWARD_LIMIT, '0);
        cfg_access(1'b0, REG_REVERSE_LIMIT, '0);
        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        // Extreme bytes, magnet off, forward on axis one, saturated axis two.
        foreach (frame_payload[i]) frame_payload[i] = (i % 2 == 0) ? 8'h00 : 8'hFF;
        frame_payload[IDX_DIGITAL] = 8'h08;
        frame_payload[IDX_AXIS1_HI] = 8'h00;
        frame_payload[IDX_AXIS1_LO] = 8'h05;
        frame_payload[IDX_AXIS2_HI] = 8'hFF;
        frame_payload[IDX_AXIS2_LO] = 8'hFF;
        send_frame(1'b0);
      end else begin
        // Drain, let the block settle, then reprogram the limits.
        while (pending_results != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        lo_lim = 10'($urandom_range(1023));
        hi_lim = 10'($urandom_range(lo_lim, 1023));
        case (seg)
          1: set_limits(10'd0, 10'd1023);
          2: set_limits(10'd1023, 10'd0);
          3: set_limits(lo_lim, hi_lim);
          4: set_limits(10'd512, 10'd512);
          default: set_limits(hi_lim, lo_lim);
        endcase
      end

      fed = 0;
      while (fed < SEG_ITEMS) begin
        if (seg == 1 && !hold_done && fed >= SEG_ITEMS / 2) begin
          long_holds_asked <= long_holds_asked + 1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 84) begin
          fill_payload();
          send_frame(pick >= 72);
          fed += 20;
        end else if (pick < 94) begin
          // Header broken at a random position.
          k = $urandom_range(1, 3);
          for (int j = 0; j < k; j++) send_byte(header_bytes[j]);
          bad = ($urandom_range(3) == 0) ? START_BYTE : 8'($urandom_range(255));
          if (bad == header_bytes[k]) bad = ~bad;
          send_byte(bad);
          fed += k + 1;
        end else begin
          k = $urandom_range(1, 4);
          repeat (k) send_byte(8'($urandom_range(255)));
          fed += k;
        end
      end
      in_valid <= 1'b0;
      @(posedge clk);
    end

    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rfjd_pkg.sv
hw/rtl/rfjd_parser.sv
hw/rtl/rfjd_drive.sv
hw/rtl/radio_frame_joystick_drive.sv
sim/rfjd_drive_checker.sv
sim/tb_top.sv
